@@ rtl/nrt_pkg.sv @@
// Neighbor route table: shared types, sizes and codes.
// No dependencies; imported by every module of the block.
package nrt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-1:0] ADDR_MAX_ROUTE_AGE = 3'd0;
	localparam logic [31:0] AGE_LIMIT_RESET = 32'd300000;

	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		ST_IMPROVED = 3'd0,
		ST_KEPT     = 3'd1,
		ST_INSERTED = 3'd2,
		ST_DROPPED  = 3'd3,
		ST_HIT      = 3'd4,
		ST_MISS     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_SEARCH,
		CS_EXEC
	} ctrl_state_t;

	typedef struct packed {
		logic              kind;
		logic [7:0]        node_id;
		logic [7:0]        hop_count;
		logic signed [7:0] signal_strength;
		logic [31:0]       now_ms;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		logic [7:0]        route_hops;
		logic signed [7:0] route_signal;
		logic [31:0]       route_stamp;
		logic [4:0]        entries_used;
		logic [31:0]       change_total;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic search;
		logic execute;
	} ctrl_cmd_t;

endpackage

@@ rtl/neighbor_route_table_top.sv @@
// Each accepted item passes through capture, id match and decide/write; the result
// is registered in the decide/write step and shown with done high.
// Busy is high until the item is decided; a new item may start while done is high.
// The id match compares all entries at once; the decide step owns the table write.
// Reset (arst_n low, asynchronous) empties the table, clears the change count
// and sets max_route_age to 300000.
module neighbor_route_table_top import nrt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  in_item_t           request,
	output logic               done,
	output out_item_t          response,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [31:0] max_age_q;
	ctrl_cmd_t   cmd;
	logic        reg_sel;

	assign reg_sel = paddr[PADDR_W-1:2] == ADDR_MAX_ROUTE_AGE[PADDR_W-1:2];
	assign pready = 1'b1;
	assign prdata = reg_sel ? max_age_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q <= AGE_LIMIT_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			max_age_q <= pwdata;
		end
	end

	nrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	nrt_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.request  (request),
		.max_age  (max_age_q),
		.response (response),
		.done     (done)
	);

endmodule

@@ rtl/nrt_ctrl.sv @@
// Neighbor route table controller: sequences capture, search and execute.
// Depends on nrt_pkg.
module nrt_ctrl import nrt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (start) begin
					state_d = CS_SEARCH;
				end
			end
			CS_SEARCH: state_d = CS_EXEC;
			CS_EXEC:   state_d = CS_IDLE;
			default:   state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b1;
		cmd = '0;
		case (state_q)
			CS_IDLE: begin
				busy = 1'b0;
				cmd.capture = start;
			end
			CS_SEARCH: cmd.search = 1'b1;
			CS_EXEC:   cmd.execute = 1'b1;
			default:   busy = 1'b1;
		endcase
	end

endmodule

@@ rtl/nrt_dp.sv @@
// Neighbor route table datapath: entry registers, parallel id match,
// update/lookup decision and result register. Depends on nrt_pkg.
module nrt_dp import nrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_cmd_t   cmd,
	input  in_item_t    request,
	input  logic [31:0] max_age,
	output out_item_t   response,
	output logic        done
);

	in_item_t          req_q;
	logic [7:0]        node_q  [TABLE_DEPTH];
	logic [7:0]        hops_q  [TABLE_DEPTH];
	logic signed [7:0] sig_q   [TABLE_DEPTH];
	logic [31:0]       stamp_q [TABLE_DEPTH];
	logic [CNT_W-1:0]  total_q;
	logic [31:0]       change_q;
	logic              hit_s1;
	logic [IDX_W-1:0]  slot_s1;
	out_item_t         result_q;
	logic              done_q;

	logic              match_any;
	logic [IDX_W-1:0]  match_slot;

	always_comb begin
		match_any = 1'b0;
		match_slot = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if ((CNT_W'(i) < total_q) && (node_q[i] == req_q.node_id)) begin
				match_any = 1'b1;
				match_slot = IDX_W'(i);
			end
		end
	end

	logic [7:0]        old_hops;
	logic signed [7:0] old_sig;
	logic [31:0]       old_stamp;
	logic [31:0]       age;
	logic              better;
	logic              room;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic [CNT_W-1:0]  total_d;
	logic [31:0]       change_d;
	out_item_t         result_d;

	always_comb begin
		old_hops = hops_q[slot_s1];
		old_sig = sig_q[slot_s1];
		old_stamp = stamp_q[slot_s1];
		age = req_q.now_ms - old_stamp;
		better = (req_q.hop_count < old_hops) ||
			((req_q.hop_count == old_hops) && (req_q.signal_strength > old_sig));
		room = total_q < CNT_W'(TABLE_DEPTH);
		wr_en = 1'b0;
		wr_idx = hit_s1 ? slot_s1 : total_q[IDX_W-1:0];
		total_d = total_q;
		change_d = change_q;
		result_d = '0;
		if (req_q.kind == KIND_UPDATE) begin
			if (hit_s1) begin
				if (better) begin
					wr_en = 1'b1;
					change_d = change_q + 32'd1;
					result_d.status = ST_IMPROVED;
				end else begin
					result_d.status = ST_KEPT;
				end
			end else if (room) begin
				wr_en = 1'b1;
				total_d = total_q + CNT_W'(1);
				change_d = change_q + 32'd1;
				result_d.status = ST_INSERTED;
			end else begin
				result_d.status = ST_DROPPED;
			end
		end else begin
			if (hit_s1 && (age < max_age)) begin
				result_d.status = ST_HIT;
				result_d.route_hops = old_hops;
				result_d.route_signal = old_sig;
				result_d.route_stamp = old_stamp;
			end else begin
				result_d.status = ST_MISS;
			end
		end
		result_d.entries_used = 5'(total_d);
		result_d.change_total = change_d;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= request;
		end
		if (cmd.search) begin
			hit_s1 <= match_any;
			slot_s1 <= match_slot;
		end
		if (cmd.execute) begin
			result_q <= result_d;
			if (wr_en) begin
				node_q[wr_idx] <= req_q.node_id;
				hops_q[wr_idx] <= req_q.hop_count;
				sig_q[wr_idx] <= req_q.signal_strength;
				stamp_q[wr_idx] <= req_q.now_ms;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			change_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.execute;
			if (cmd.execute) begin
				total_q <= total_d;
				change_q <= change_d;
			end
		end
	end

	assign response = result_q;
	assign done = done_q;

endmodule

@@ rtl/nrt_checker.sv @@
// Port-level checks for the neighbor route table.
// Depends on nrt_pkg; bound to neighbor_route_table_top.
module nrt_checker import nrt_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input out_item_t response
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result missing three cycles after accept");

	a_update_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (response.status == ST_IMPROVED || response.status == ST_KEPT ||
			response.status == ST_INSERTED || response.status == ST_DROPPED ||
			response.status == ST_MISS)) |->
		(response.route_hops == 8'd0 && response.route_signal == 8'sd0 &&
			response.route_stamp == 32'd0))
		else $error("route fields nonzero without a lookup hit");

endmodule

bind neighbor_route_table_top nrt_checker u_nrt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.response (response)
);

@@ tb/testbench.sv @@
// Testbench for neighbor_route_table_top: directed and random update/lookup items,
// each result checked field by field against a predictor of the route table.
// Depends on nrt_pkg and the RTL of the block only.
module testbench;
	import nrt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 1000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	in_item_t           request = '0;
	logic               done;
	out_item_t          response;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	// predictor state
	logic [7:0]        tbl_node [TABLE_DEPTH];
	logic [7:0]        tbl_hops [TABLE_DEPTH];
	logic signed [7:0] tbl_signal [TABLE_DEPTH];
	logic [31:0]       tbl_stamp [TABLE_DEPTH];
	int                tbl_used = 0;
	logic [31:0]       tbl_changes = '0;
	logic [31:0]       age_limit = AGE_LIMIT_RESET;

	out_item_t   pending_routes [$];
	int          errors = 0;
	int          stall_cycles = 0;
	bit          idle_on = 1'b1;
	logic [31:0] sim_ms = '0;

	neighbor_route_table_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.response (response),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic out_item_t predict_route(input in_item_t it);
		out_item_t   r;
		int          slot;
		logic [31:0] age;
		r = '0;
		slot = -1;
		for (int i = 0; i < tbl_used; i++)
			if (slot < 0 && tbl_node[i] == it.node_id)
				slot = i;
		if (it.kind == KIND_UPDATE) begin
			if (slot >= 0) begin
				if (it.hop_count < tbl_hops[slot] ||
				    (it.hop_count == tbl_hops[slot] &&
				     $signed(it.signal_strength) > $signed(tbl_signal[slot]))) begin
					tbl_hops[slot] = it.hop_count;
					tbl_signal[slot] = it.signal_strength;
					tbl_stamp[slot] = it.now_ms;
					tbl_changes = tbl_changes + 32'd1;
					r.status = ST_IMPROVED;
				end else begin
					r.status = ST_KEPT;
				end
			end else if (tbl_used < TABLE_DEPTH) begin
				tbl_node[tbl_used] = it.node_id;
				tbl_hops[tbl_used] = it.hop_count;
				tbl_signal[tbl_used] = it.signal_strength;
				tbl_stamp[tbl_used] = it.now_ms;
				tbl_used = tbl_used + 1;
				tbl_changes = tbl_changes + 32'd1;
				r.status = ST_INSERTED;
			end else begin
				r.status = ST_DROPPED;
			end
		end else begin
			r.status = ST_MISS;
			if (slot >= 0) begin
				age = it.now_ms - tbl_stamp[slot];
				if (age < age_limit) begin
					r.status = ST_HIT;
					r.route_hops = tbl_hops[slot];
					r.route_signal = tbl_signal[slot];
					r.route_stamp = tbl_stamp[slot];
				end
			end
		end
		r.entries_used = 5'(tbl_used);
		r.change_total = tbl_changes;
		return r;
	endfunction

	task automatic report_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (pending_routes.size() == 0) begin
			$display("%0t: result with no item pending, expected none, actual status %0d",
			         $time, got.status);
			errors++;
		end else begin
			want = pending_routes.pop_front();
			report_field("status", want.status, got.status);
			report_field("route_hops", want.route_hops, got.route_hops);
			report_field("route_signal", want.route_signal, got.route_signal);
			report_field("route_stamp", want.route_stamp, got.route_stamp);
			report_field("entries_used", want.entries_used, got.entries_used);
			report_field("change_total", want.change_total, got.change_total);
		end
	endtask

	always @(posedge clk) begin
		logic progress;
		progress = 1'b0;
		if (arst_n) begin
			if (done) begin
				progress = 1'b1;
				check_result(response);
			end
			if (psel && penable && pready) begin
				progress = 1'b1;
				if (pwrite && paddr == ADDR_MAX_ROUTE_AGE)
					age_limit = pwdata;
			end
			if (start && !busy) begin
				progress = 1'b1;
				pending_routes.push_back(predict_route(request));
			end
			if (progress) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
					$display("simulation failed");
					$finish;
				end
			end
		end
	end

	function automatic in_item_t route_item(input logic kind, input logic [7:0] id,
	                                        input logic [7:0] hops, input logic [7:0] sig,
	                                        input logic [31:0] now);
		in_item_t it;
		it.kind = kind;
		it.node_id = id;
		it.hop_count = hops;
		it.signal_strength = sig;
		it.now_ms = now;
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start <= 1'b1;
		request <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic drain_items();
		@(negedge clk);
		start <= 1'b0;
		while (pending_routes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
	                          input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (!wr && prdata !== age_limit) begin
			$display("%0t: max_route_age readback mismatch, expected %0h, actual %0h",
			         $time, age_limit, prdata);
			errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_age_limit(input logic [31:0] value);
		drain_items();
		apb_access(1'b1, ADDR_MAX_ROUTE_AGE, value);
		apb_access(1'b0, ADDR_MAX_ROUTE_AGE, '0);
	endtask

	task automatic test_empty_table();
		apb_access(1'b0, ADDR_MAX_ROUTE_AGE, '0);
		send_item(route_item(KIND_LOOKUP, 8'h00, 8'hff, 8'hff, 32'd0));
	endtask

	task automatic test_update_rules();
		send_item(route_item(KIND_UPDATE, 8'h00, 8'd255, 8'h80, 32'd100));
		send_item(route_item(KIND_UPDATE, 8'hff, 8'd0, 8'h7f, 32'hffff_ffff));
		send_item(route_item(KIND_UPDATE, 8'h00, 8'd254, 8'h80, 32'd200));
		send_item(route_item(KIND_UPDATE, 8'h00, 8'd254, 8'h81, 32'd300));
		send_item(route_item(KIND_UPDATE, 8'h00, 8'd254, 8'h81, 32'd400));
		send_item(route_item(KIND_UPDATE, 8'h00, 8'd254, 8'h80, 32'd500));
		send_item(route_item(KIND_UPDATE, 8'h00, 8'd255, 8'h7f, 32'd600));
		send_item(route_item(KIND_LOOKUP, 8'h00, 8'h00, 8'h00, 32'd1000));
		send_item(route_item(KIND_LOOKUP, 8'h5a, 8'h00, 8'h00, 32'd1000));
		// stamp just below the wrap, lookup just after it
		send_item(route_item(KIND_LOOKUP, 8'hff, 8'h00, 8'h00, 32'd5));
	endtask

	task automatic test_age_limits();
		set_age_limit(32'd1000);
		send_item(route_item(KIND_LOOKUP, 8'h00, 8'h00, 8'h00, 32'd1299));
		send_item(route_item(KIND_LOOKUP, 8'h00, 8'h00, 8'h00, 32'd1300));
		send_item(route_item(KIND_LOOKUP, 8'h00, 8'h00, 8'h00, 32'd299));
		set_age_limit(32'd0);
		send_item(route_item(KIND_LOOKUP, 8'h00, 8'h00, 8'h00, 32'd300));
		set_age_limit(32'hffff_ffff);
		send_item(route_item(KIND_LOOKUP, 8'h00, 8'h00, 8'h00, 32'd299));
		send_item(route_item(KIND_LOOKUP, 8'h00, 8'h00, 8'h00, 32'h8000_0000));
	endtask

	task automatic test_table_full();
		for (int i = 2; i < TABLE_DEPTH; i++)
			send_item(route_item(KIND_UPDATE, 8'(8'h10 + i), 8'(i), 8'(i - 8), 32'(1000 + i)));
		send_item(route_item(KIND_UPDATE, 8'ha5, 8'd0, 8'h7f, 32'd2000));
		send_item(route_item(KIND_LOOKUP, 8'ha5, 8'd0, 8'h00, 32'd2000));
	endtask

	task automatic test_random_routes(input logic [31:0] limit, input int count, input bit idle);
		in_item_t it;
		int       slot;
		set_age_limit(limit);
		idle_on = idle;
		for (int n = 0; n < count; n++) begin
			it = '0;
			it.kind = ($urandom_range(0, 99) < 45) ? KIND_LOOKUP : KIND_UPDATE;
			if ($urandom_range(0, 99) < 80 && tbl_used > 0) begin
				slot = $urandom_range(0, tbl_used - 1);
				it.node_id = tbl_node[slot];
				case ($urandom_range(0, 3))
					0: it.hop_count = 8'($urandom_range(0, 255));
					1: it.hop_count = tbl_hops[slot];
					2: it.hop_count = tbl_hops[slot] - 8'd1;
					default: it.hop_count = tbl_hops[slot] + 8'd1;
				endcase
				if ($urandom_range(0, 1))
					it.signal_strength = 8'($urandom_range(0, 255));
				else
					it.signal_strength = tbl_signal[slot] + 8'($urandom_range(0, 2)) - 8'd1;
			end else begin
				it.node_id = 8'($urandom_range(0, 255));
				it.hop_count = 8'($urandom_range(0, 255));
				it.signal_strength = 8'($urandom_range(0, 255));
			end
			sim_ms = sim_ms + 32'($urandom_range(0, 400));
			if ($urandom_range(0, 49) == 0)
				sim_ms = $urandom();
			it.now_ms = ($urandom_range(0, 29) == 0) ? 32'($urandom()) : sim_ms;
			send_item(it);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_empty_table();
		test_update_rules();
		test_age_limits();
		test_table_full();
		test_random_routes(AGE_LIMIT_RESET, 250, 1'b1);
		test_random_routes(32'd1000, 250, 1'b1);
		test_random_routes(32'd0, 150, 1'b0);
		test_random_routes($urandom(), 250, 1'b1);
		test_random_routes(32'hffff_ffff, 300, 1'b0);
		drain_items();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
